/* sv/tst_pkg.sv */
// Shared types, request codes and helpers of the timed signal table.
package tst_pkg;

    localparam int TYPE_W = 3;
    localparam int CODE_W = 8;
    localparam int TIME_W = 32;

    localparam logic [TYPE_W-1:0] REQ_ADVANCE      = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_FIRE         = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_ADD          = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_CHECK        = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_CLEAR        = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_CLEAR_OTHERS = 3'd5;

    typedef enum logic [2:0] {
        OP_ADVANCE,
        OP_FIRE,
        OP_ADD,
        OP_CHECK,
        OP_CLEAR,
        OP_CLEAR_OTHERS,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] delay;
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    function automatic logic op_scans(t_op op);
        logic r;
        r = (op == OP_FIRE) || (op == OP_ADD) || (op == OP_CHECK) ||
            (op == OP_CLEAR) || (op == OP_CLEAR_OTHERS);
        return r;
    endfunction

endpackage

/* sv/tst_ram.sv */
// Generic single write port RAM with one registered read port.
module tst_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/tst_front.sv */
// Front end: accepts request beats, decodes the request type and queues them.
module tst_front
    import tst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [TYPE_W-1:0] i_req_type,
    input  logic [CODE_W-1:0] i_signal_code,
    input  logic [TIME_W-1:0] i_delay_ticks,
    output logic              o_req_valid,
    output t_req              o_req,
    input  logic              i_req_pop
);

    t_req       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       push;
    t_req       dec;

    always_comb begin
        dec.code  = i_signal_code;
        dec.delay = i_delay_ticks;
        unique case (i_req_type)
            REQ_ADVANCE:      dec.op = OP_ADVANCE;
            REQ_FIRE:         dec.op = OP_FIRE;
            REQ_ADD:          dec.op = OP_ADD;
            REQ_CHECK:        dec.op = OP_CHECK;
            REQ_CLEAR:        dec.op = OP_CLEAR;
            REQ_CLEAR_OTHERS: dec.op = OP_CLEAR_OTHERS;
            default:          dec.op = OP_NONE;
        endcase
    end

    assign o_in_stall  = (r_count == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_req_valid = (r_count != 2'd0);
    assign o_req       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_req_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, push} - {1'b0, i_req_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec;
        end
    end

endmodule

/* sv/tst_back.sv */
// Back end: epoch counter, slot table and the slot scan sequencer with result register.
module tst_back
    import tst_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_req i_req,
    output logic o_req_pop,
    output logic o_out_valid,
    input  logic i_out_stall,
    output logic o_hit
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW = CODE_W + TIME_W;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    t_state            r_state, n_state;
    t_op               r_op;
    logic [CODE_W-1:0] r_code;
    logic [TIME_W-1:0] r_due;
    logic [TIME_W-1:0] r_epoch;
    logic [IW-1:0]     r_ev_idx, n_ev_idx;
    logic              r_hit, n_hit;
    logic [SLOTS-1:0]  r_free, n_free;
    logic [SLOTS-1:0]  r_fired, n_fired;
    logic              r_out_valid, n_out_valid;
    logic              r_out_hit;

    logic              found;
    logic              ram_we;
    logic [IW-1:0]     rd_addr;
    logic [DW-1:0]     rd_data;
    logic [CODE_W-1:0] ev_code;
    logic [TIME_W-1:0] ev_due;
    logic              out_free;

    tst_ram #(
        .WIDTH(DW),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_ev_idx),
        .i_wdata({r_code, r_due}),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    assign ev_code  = rd_data[DW-1:TIME_W];
    assign ev_due   = rd_data[TIME_W-1:0];
    assign out_free = !r_out_valid || !i_out_stall;

    // The read of the next slot is issued while the current one is evaluated.
    assign n_ev_idx = (r_state == S_SCAN && r_ev_idx != LAST) ? r_ev_idx + 1'b1 : '0;
    assign rd_addr  = n_ev_idx;

    // Slot evaluation during the scan.
    always_comb begin
        found   = 1'b0;
        ram_we  = 1'b0;
        n_free  = r_free;
        n_fired = r_fired;
        n_hit   = r_hit;
        if (r_state == S_SCAN) begin
            unique case (r_op)
                OP_FIRE: begin
                    if (!r_free[r_ev_idx] && !r_fired[r_ev_idx] && ev_due == r_epoch) begin
                        n_fired[r_ev_idx] = 1'b1;
                    end
                end
                OP_ADD: begin
                    if (r_free[r_ev_idx]) begin
                        ram_we            = 1'b1;
                        n_free[r_ev_idx]  = 1'b0;
                        n_fired[r_ev_idx] = 1'b0;
                        found             = 1'b1;
                    end
                end
                OP_CHECK: begin
                    if (!r_free[r_ev_idx] && r_fired[r_ev_idx] && ev_code == r_code) begin
                        n_free[r_ev_idx] = 1'b1;
                        n_hit            = 1'b1;
                        found            = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    if (!r_free[r_ev_idx] && ev_code == r_code) begin
                        n_free[r_ev_idx] = 1'b1;
                    end
                end
                OP_CLEAR_OTHERS: begin
                    if (!r_free[r_ev_idx] && ev_code != r_code) begin
                        n_free[r_ev_idx] = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = op_scans(i_req.op) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (found || r_ev_idx == LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_req_pop   = (r_state == S_IDLE) && i_req_valid;
        n_out_valid = (r_out_valid && i_out_stall) || (r_state == S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_epoch     <= '0;
            r_free      <= '1;
            r_fired     <= '0;
            r_out_valid <= 1'b0;
            r_ev_idx    <= '0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_fired     <= n_fired;
            r_out_valid <= n_out_valid;
            r_ev_idx    <= n_ev_idx;
            if (o_req_pop && i_req.op == OP_ADVANCE) begin
                r_epoch <= r_epoch + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_op   <= i_req.op;
            r_code <= i_req.code;
            r_due  <= r_epoch + i_req.delay;
            r_hit  <= 1'b0;
        end else begin
            r_hit  <= n_hit;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_hit <= r_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;

endmodule

/* sv/timed_signal_table.sv */
// Timed signal table: request queue, slot scan engine and result register.
// Advance and unused request types need no scan; fire, add, check, clear and
// clear-others scan the slots, one slot a cycle over the code and due-time RAM.
// A scanning request occupies the back end until its scan ends; add and check stop
// at the first matching slot.
// Synchronous reset zeroes the epoch, marks every slot free and empties the queue
// at once; the RAM needs no clearing pass.
module timed_signal_table
    import tst_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [TYPE_W-1:0] i_req_type,
    input  logic [CODE_W-1:0] i_signal_code,
    input  logic [TIME_W-1:0] i_delay_ticks,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_hit
);

    logic req_valid;
    t_req req;
    logic req_pop;

    tst_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_signal_code(i_signal_code),
        .i_delay_ticks(i_delay_ticks),
        .o_req_valid  (req_valid),
        .o_req        (req),
        .i_req_pop    (req_pop)
    );

    tst_back #(
        .SLOTS(SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(req_valid),
        .i_req      (req),
        .o_req_pop  (req_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_hit      (o_hit)
    );

endmodule

/* sv/tst_checker.sv */
// Port-level checker for the timed signal table and its bind statement.
module tst_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_hit
);

    // A stalled result beat keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_hit)))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Reset empties the request queue.
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // A full queue cannot come out of an idle input side.
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_in_stall)) |-> $past(i_in_valid))
        else $error("queue filled without an input beat");

endmodule

bind timed_signal_table tst_checker u_chk (.*);
